### design/ewspd_pkg.sv
package ewspd_pkg;

    localparam int DIST_W    = 24;
    localparam int SPEED_W   = 32;
    localparam int STEP_W    = 40;
    localparam int CNT_IN_W  = 16;
    localparam int TIM_IN_W  = 32;
    localparam int DATA_IN_W = CNT_IN_W + TIM_IN_W;
    localparam int DATA_OUT_W = SPEED_W + STEP_W;

    localparam logic [DIST_W-1:0] DIST_RESET = 24'd130900;

    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

### design/ewspd_ring.sv
module ewspd_ring #(
    parameter int SAMPLES    = 8,
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [COUNT_BITS-1:0]      i_base_cnt,
    input  logic [TIME_BITS-1:0]       i_base_tim,
    input  logic                       i_wr_en,
    input  logic [$clog2(SAMPLES)-1:0] i_wr_addr,
    input  logic [COUNT_BITS-1:0]      i_wr_cnt,
    input  logic [TIME_BITS-1:0]       i_wr_tim,
    input  logic                       i_rd_en,
    input  logic [$clog2(SAMPLES)-1:0] i_rd_addr_a,
    input  logic [$clog2(SAMPLES)-1:0] i_rd_addr_b,
    output logic [COUNT_BITS-1:0]      o_cnt_a,
    output logic [COUNT_BITS-1:0]      o_cnt_b,
    output logic [TIME_BITS-1:0]       o_tim_b
);

    localparam int EW = COUNT_BITS + TIME_BITS;

    logic [EW-1:0]         r_mem [SAMPLES];
    logic [SAMPLES-1:0]    r_valid;
    logic [EW-1:0]         r_base;
    logic [COUNT_BITS-1:0] r_rd_a;
    logic [EW-1:0]         r_rd_b;
    logic                  r_va;
    logic                  r_vb;
    logic [EW-1:0]         sel_b;

    // entries not written since the last restart read as the restart value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_base  <= '0;
        end else if (i_restart) begin
            r_valid <= '0;
            r_base  <= {i_base_tim, i_base_cnt};
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_tim, i_wr_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a][COUNT_BITS-1:0];
            r_rd_b <= r_mem[i_rd_addr_b];
            r_va   <= r_valid[i_rd_addr_a];
            r_vb   <= r_valid[i_rd_addr_b];
        end
    end

    assign sel_b   = r_vb ? r_rd_b : r_base;
    assign o_cnt_a = r_va ? r_rd_a : r_base[COUNT_BITS-1:0];
    assign o_cnt_b = sel_b[COUNT_BITS-1:0];
    assign o_tim_b = sel_b[EW-1:COUNT_BITS];

endmodule

### design/ewspd_mul.sv
module ewspd_mul #(
    parameter int A_W = 24,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = $clog2(B_W + 1);

    logic [P_W-1:0] r_acc;
    logic [A_W-1:0] r_mcand;
    logic [C_W-1:0] r_left;
    logic [A_W:0]   sum;

    // one multiplier bit per cycle, lsb first
    assign sum = {1'b0, r_acc[P_W-1:B_W]} + (r_acc[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= C_W'(B_W);
        end else if (r_left != '0) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= {{A_W{1'b0}}, i_b};
            r_mcand <= i_a;
        end else if (r_left != '0) begin
            r_acc   <= {sum, r_acc[B_W-1:1]};
        end
    end

    assign o_busy = (r_left != '0);
    assign o_prod = r_acc;

endmodule

### design/ewspd_div.sv
module ewspd_div #(
    parameter int N_W = 40,
    parameter int D_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quo
);

    localparam int C_W = $clog2(N_W + 1);

    logic [N_W-1:0] r_q;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [C_W-1:0] r_left;
    logic [D_W:0]   shifted;
    logic [D_W+1:0] diff;

    // restoring division, one quotient bit per cycle
    assign shifted = {r_rem, r_q[N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= C_W'(N_W);
        end else if (r_left != '0) begin
            r_left <= r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_left != '0) begin
            if (diff[D_W+1]) begin
                r_rem <= shifted[D_W-1:0];
                r_q   <= {r_q[N_W-2:0], 1'b0};
            end else begin
                r_rem <= diff[D_W-1:0];
                r_q   <= {r_q[N_W-2:0], 1'b1};
            end
        end
    end

    assign o_busy = (r_left != '0);
    assign o_quo  = r_q;

endmodule

### design/encoder_window_speed.sv
// Encoder window speed estimator. Each sample transfer (tuser = 0) stores the
// counter reading and microsecond timestamp in a ring of SAMPLES entries and
// produces one result transfer: the window speed in mm/s (count change against
// the oldest entry times the distance per pulse, over the time span, truncated
// toward zero and saturated, 0 on a zero span) and the last step distance in
// nm (held on a zero span). A restart transfer (tuser = 1) refills the window
// with the given reading and produces nothing. A sample passes through two
// bit-serial shift-add multipliers running in parallel and then a restoring
// divider, one item at a time. A finished result waits in the output register
// while the next sample is taken in. The distance per pulse register resets
// to 130900 nm and may be written whenever the block is idle.
module encoder_window_speed #(
    parameter int SAMPLES    = 8,
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ewspd_pkg::DIST_W-1:0]        i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // counter_value, timestamp_us
    input  logic [ewspd_pkg::DATA_IN_W-1:0]     s_axis_tdata,
    // func
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // speed_mm_s, last_step_nm
    output logic [ewspd_pkg::DATA_OUT_W-1:0]    m_axis_tdata
);

    localparam int AW  = $clog2(SAMPLES);
    localparam int DW  = ewspd_pkg::DIST_W;
    localparam int PW  = DW + COUNT_BITS;
    localparam int SPW = ewspd_pkg::SPEED_W;
    localparam int STW = ewspd_pkg::STEP_W;
    localparam int LW  = ((PW > STW) ? PW : STW) + 1;

    localparam logic [AW-1:0] SLOT_LAST = AW'(SAMPLES - 1);
    localparam logic [LW-1:0] SP_POS_LIM = (LW'(1) << (SPW - 1)) - LW'(1);
    localparam logic [LW-1:0] SP_NEG_LIM = LW'(1) << (SPW - 1);
    localparam logic [LW-1:0] ST_POS_LIM = (LW'(1) << (STW - 1)) - LW'(1);
    localparam logic [LW-1:0] ST_NEG_LIM = LW'(1) << (STW - 1);

    ewspd_pkg::t_state r_state;
    ewspd_pkg::t_state n_state;

    logic [DW-1:0]         r_dist;
    logic [AW-1:0]         r_slot;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [TIME_BITS-1:0]  r_tim;
    logic                  r_step_neg;
    logic                  r_win_neg;
    logic                  r_span_zero;
    logic [TIME_BITS-1:0]  r_span;
    logic [STW-1:0]        r_held;
    logic                  r_out_valid;
    logic [SPW-1:0]        r_out_speed;
    logic [STW-1:0]        r_out_step;

    logic                  accept;
    logic                  restart;
    logic                  sample;
    logic [COUNT_BITS-1:0] in_cnt;
    logic [TIME_BITS-1:0]  in_tim;
    logic [AW-1:0]         slot_cur;
    logic [AW-1:0]         slot_old;
    logic [COUNT_BITS-1:0] cnt_prev;
    logic [COUNT_BITS-1:0] cnt_old;
    logic [TIME_BITS-1:0]  tim_old;
    logic [COUNT_BITS-1:0] d_step;
    logic [COUNT_BITS-1:0] d_win;
    logic [COUNT_BITS-1:0] m_step;
    logic [COUNT_BITS-1:0] m_win;
    logic [TIME_BITS-1:0]  span;
    logic                  mul_start;
    logic                  div_start;
    logic                  load_out;
    logic                  step_busy;
    logic                  win_busy;
    logic                  div_busy;
    logic [PW-1:0]         step_prod;
    logic [PW-1:0]         win_prod;
    logic [PW-1:0]         quo;
    logic [LW-1:0]         q_ext;
    logic [LW-1:0]         q_neg;
    logic [LW-1:0]         p_ext;
    logic [LW-1:0]         p_neg;
    logic [SPW-1:0]        speed_sat;
    logic [STW-1:0]        step_sat;

    assign in_cnt  = COUNT_BITS'(s_axis_tdata[ewspd_pkg::CNT_IN_W-1:0]);
    assign in_tim  = TIME_BITS'(s_axis_tdata[ewspd_pkg::DATA_IN_W-1:ewspd_pkg::CNT_IN_W]);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign restart = accept && (s_axis_tuser == ewspd_pkg::FUNC_RESTART);
    assign sample  = accept && (s_axis_tuser == ewspd_pkg::FUNC_SAMPLE);

    assign slot_cur = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
    assign slot_old = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;

    ewspd_ring #(
        .SAMPLES    (SAMPLES),
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_base_cnt  (in_cnt),
        .i_base_tim  (in_tim),
        .i_wr_en     (sample),
        .i_wr_addr   (slot_cur),
        .i_wr_cnt    (in_cnt),
        .i_wr_tim    (in_tim),
        .i_rd_en     (sample),
        .i_rd_addr_a (r_slot),
        .i_rd_addr_b (slot_old),
        .o_cnt_a     (cnt_prev),
        .o_cnt_b     (cnt_old),
        .o_tim_b     (tim_old)
    );

    // wrapped differences, split into sign and magnitude for the serial units
    assign d_step = r_cnt - cnt_prev;
    assign d_win  = r_cnt - cnt_old;
    assign m_step = d_step[COUNT_BITS-1] ? ('0 - d_step) : d_step;
    assign m_win  = d_win[COUNT_BITS-1] ? ('0 - d_win) : d_win;
    assign span   = r_tim - tim_old;

    ewspd_mul #(.A_W(DW), .B_W(COUNT_BITS)) u_mul_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_dist),
        .i_b     (m_step),
        .o_busy  (step_busy),
        .o_prod  (step_prod)
    );

    ewspd_mul #(.A_W(DW), .B_W(COUNT_BITS)) u_mul_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_dist),
        .i_b     (m_win),
        .o_busy  (win_busy),
        .o_prod  (win_prod)
    );

    ewspd_div #(.N_W(PW), .D_W(TIME_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (win_prod),
        .i_den   (r_span),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // saturation to the signed output ranges
    always_comb begin
        q_ext = LW'(quo);
        q_neg = LW'(0) - q_ext;
        p_ext = LW'(step_prod);
        p_neg = LW'(0) - p_ext;
        if (r_span_zero) begin
            speed_sat = '0;
        end else if (!r_win_neg) begin
            speed_sat = (q_ext > SP_POS_LIM) ? {1'b0, {(SPW-1){1'b1}}} : q_ext[SPW-1:0];
        end else begin
            speed_sat = (q_ext > SP_NEG_LIM) ? {1'b1, {(SPW-1){1'b0}}} : q_neg[SPW-1:0];
        end
        if (r_span_zero) begin
            step_sat = r_held;
        end else if (!r_step_neg) begin
            step_sat = (p_ext > ST_POS_LIM) ? {1'b0, {(STW-1){1'b1}}} : p_ext[STW-1:0];
        end else begin
            step_sat = (p_ext > ST_NEG_LIM) ? {1'b1, {(STW-1){1'b0}}} : p_neg[STW-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        mul_start     = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            ewspd_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (sample) begin
                    n_state = ewspd_pkg::ST_READ;
                end
            end
            ewspd_pkg::ST_READ: begin
                mul_start = 1'b1;
                n_state   = ewspd_pkg::ST_MUL;
            end
            ewspd_pkg::ST_MUL: begin
                if (!step_busy && !win_busy) begin
                    div_start = 1'b1;
                    n_state   = ewspd_pkg::ST_DIV;
                end
            end
            ewspd_pkg::ST_DIV: begin
                if (!div_busy) begin
                    n_state = ewspd_pkg::ST_OUT;
                end
            end
            ewspd_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ewspd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ewspd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ewspd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist      <= ewspd_pkg::DIST_RESET;
            r_slot      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_dist <= i_cfg_wr_data;
            end
            if (restart) begin
                r_slot <= '0;
            end else if (sample) begin
                r_slot <= slot_cur;
            end
            if (load_out) begin
                r_held      <= step_sat;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_cnt <= in_cnt;
            r_tim <= in_tim;
        end
        if (mul_start) begin
            r_step_neg  <= d_step[COUNT_BITS-1];
            r_win_neg   <= d_win[COUNT_BITS-1];
            r_span      <= span;
            r_span_zero <= (span == '0);
        end
        if (load_out) begin
            r_out_speed <= speed_sat;
            r_out_step  <= step_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_step, r_out_speed};

endmodule

### test/encoder_window_speed_test.sv
`timescale 1ns / 100ps

module encoder_window_speed_test;

    localparam int SAMPLES       = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 205;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 600;

    localparam int DIST_W     = ewspd_pkg::DIST_W;
    localparam int CNT_IN_W   = ewspd_pkg::CNT_IN_W;
    localparam int TIM_IN_W   = ewspd_pkg::TIM_IN_W;
    localparam int STEP_W     = ewspd_pkg::STEP_W;
    localparam int SPEED_W    = ewspd_pkg::SPEED_W;
    localparam int DATA_IN_W  = ewspd_pkg::DATA_IN_W;
    localparam int DATA_OUT_W = ewspd_pkg::DATA_OUT_W;

    localparam longint STEP_MAX  = (longint'(1) <<< (STEP_W - 1)) - 1;
    localparam longint STEP_MIN  = -(longint'(1) <<< (STEP_W - 1));
    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // step in the upper bits, speed in the lower bits, as on the master tdata
    typedef struct packed {
        logic signed [STEP_W-1:0]  step;
        logic signed [SPEED_W-1:0] speed;
    } t_result;

    class window_speed_scoreboard;
        logic [DIST_W-1:0]   dist_nm;
        logic [CNT_IN_W-1:0] count_ring [SAMPLES];
        logic [TIM_IN_W-1:0] time_ring [SAMPLES];
        int unsigned         slot;
        longint              held_step;
        t_result             pending_results [$];
        int unsigned         samples, restarts, checked, errors;

        function new();
            dist_nm = ewspd_pkg::DIST_RESET;
            foreach (count_ring[i]) begin
                count_ring[i] = '0;
                time_ring[i]  = '0;
            end
            slot      = 0;
            held_step = 0;
        endfunction

        function longint count_delta(logic [CNT_IN_W-1:0] a, logic [CNT_IN_W-1:0] b);
            logic [CNT_IN_W-1:0] d;
            d = a - b;
            return longint'($signed(d));
        endfunction

        function void take_input(logic func, logic [CNT_IN_W-1:0] cnt,
                                 logic [TIM_IN_W-1:0] tim);
            int unsigned         prev, cur, old;
            logic [TIM_IN_W-1:0] span;
            longint              step_nm, num, speed;
            t_result             r;
            if (func == ewspd_pkg::FUNC_RESTART) begin
                foreach (count_ring[i]) begin
                    count_ring[i] = cnt;
                    time_ring[i]  = tim;
                end
                slot = 0;
                restarts++;
                return;
            end
            samples++;
            prev = slot;
            cur  = (prev + 1) % SAMPLES;
            old  = (cur + 1) % SAMPLES;
            slot = cur;
            count_ring[cur] = cnt;
            time_ring[cur]  = tim;
            span  = time_ring[cur] - time_ring[old];
            speed = 0;
            if (span != 0) begin
                step_nm = longint'(dist_nm) * count_delta(cnt, count_ring[prev]);
                num     = longint'(dist_nm) * count_delta(cnt, count_ring[old]);
                if (step_nm > STEP_MAX) step_nm = STEP_MAX;
                if (step_nm < STEP_MIN) step_nm = STEP_MIN;
                held_step = step_nm;
                speed = num / longint'(span);
                if (speed > SPEED_MAX) speed = SPEED_MAX;
                if (speed < SPEED_MIN) speed = SPEED_MIN;
            end
            r.speed = speed[SPEED_W-1:0];
            r.step  = held_step[STEP_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t result with nothing pending: speed %0d step %0d",
                         $time, got.speed, got.step);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.speed !== want.speed) begin
                $display("%0t speed_mm_s mismatch: expected %0d, actual %0d",
                         $time, want.speed, got.speed);
                errors++;
            end
            if (got.step !== want.step) begin
                $display("%0t last_step_nm mismatch: expected %0d, actual %0d",
                         $time, want.step, got.step);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [DIST_W-1:0]     i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_axis_tdata;

    window_speed_scoreboard sb;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    bit          hold_done      = 1'b0;
    int          hold_left      = 0;

    encoder_window_speed dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each transfer, then pick the next tready
    always @(posedge i_clk) begin
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(t_result'(m_axis_tdata));
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** encoder_window_speed: FAILED **");
        $finish;
    end

    task automatic send_item(logic func, logic [CNT_IN_W-1:0] cnt, logic [TIM_IN_W-1:0] tim);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tim, cnt};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.take_input(func, cnt, tim);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dist(logic [DIST_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.dist_nm = value;
    endtask

    task automatic set_idle(t_idle mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default:   begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    function automatic logic [DIST_W-1:0] phase_dist(int p);
        case (p)
            1:       return 24'd1;
            2:       return 24'hFFFFFF;
            3:       return 24'd0;
            4:       return DIST_W'($urandom_range(1, 24'hFFFFFF));
            5:       return ewspd_pkg::DIST_RESET;
            6:       return DIST_W'($urandom_range(1, 1000));
            default: return 24'hFFFFFF;
        endcase
    endfunction

    function automatic int count_step();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(0, 65535);
            default: return int'($urandom_range(800)) - 400;
        endcase
    endfunction

    function automatic logic [TIM_IN_W-1:0] time_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    task automatic run_directed();
        int k;
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'h0000, 32'h00000000);
        send_item(ewspd_pkg::FUNC_RESTART, 16'hFFFF, 32'hFFFFFFFF);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'h0000, 32'h00000000);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'h8000, 32'h00000000);
        send_item(ewspd_pkg::FUNC_RESTART, 16'h0000, 32'h00000000);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'h7FFF, 32'h00000001);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'h7FFF, 32'h00000001);
        send_item(ewspd_pkg::FUNC_RESTART, 16'd100,  32'd5000);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'd200,  32'd5000);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'd300,  32'd6000);
        send_item(ewspd_pkg::FUNC_RESTART, 16'h0000, 32'h00000000);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'hFFFF, 32'hFFFFFFFF);
        send_item(ewspd_pkg::FUNC_SAMPLE,  16'hFFFE, 32'hFFFFFFFF);
        // full turn of the ring with a steady rate
        for (k = 1; k <= SAMPLES + 1; k++)
            send_item(ewspd_pkg::FUNC_SAMPLE, CNT_IN_W'(k * 1000), TIM_IN_W'(k * 700 + 3));
    endtask

    task automatic run_random(int n);
        int                  sent, len, k;
        logic [CNT_IN_W-1:0] c;
        logic [TIM_IN_W-1:0] t;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 80) begin
                c = $urandom;
                t = $urandom;
                if ($urandom_range(3) != 0) begin
                    send_item(ewspd_pkg::FUNC_RESTART, c, t);
                    sent++;
                end
                len = $urandom_range(1, 20);
                for (k = 0; k < len; k++) begin
                    c = c + CNT_IN_W'(count_step());
                    t = t + time_step();
                    send_item(ewspd_pkg::FUNC_SAMPLE, c, t);
                    sent++;
                end
            end else begin
                send_item(1'($urandom_range(1)), CNT_IN_W'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    initial begin : main
        int p;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        for (p = 0; p < PHASES; p++) begin
            set_idle(t_idle'(p % 4));
            if (p > 0)
                write_dist(phase_dist(p));
            if (p == 0)
                hold_req = 1'b1;
            run_random(PHASE_ITEMS);
            drain();
        end
        if (sb.pending_results.size() != 0) begin
            $display("%0t %0d results never arrived", $time, sb.pending_results.size());
            sb.errors++;
        end
        $display("covered %0d samples and %0d restarts, %0d results checked, %0d errors",
                 sb.samples, sb.restarts, sb.checked, sb.errors);
        $display("distance per pulse from 0 to full scale over %0d phases of mixed idling",
                 PHASES);
        if (sb.errors == 0)
            $display("** encoder_window_speed: PASSED **");
        else
            $display("** encoder_window_speed: FAILED **");
        $finish;
    end

endmodule
